>>> design/pbsf_pkg.sv
package pbsf_pkg;

  localparam int unsigned DW     = 32;
  localparam int unsigned FB     = 16;
  localparam int unsigned UW     = DW - 1;   // unsigned field width
  localparam int unsigned ADDR_W = 3;

  localparam logic [UW-1:0] SMAX            = {UW{1'b1}};
  localparam logic [31:0]   LIMIT_COEF_Q32  = 32'd4047911311;   // 0.3*pi in Q0.32
  localparam logic [UW-1:0] STEP_TIME_RESET = UW'(1) << FB;

  // register index, taken from the word-aligned address
  localparam logic REG_STEP_TIME = 1'b0;

  // carried beside the k1 / first kmax divide
  typedef struct packed {
    logic                 pinned;
    logic [UW-1:0]        m;
    logic [2:0][DW-1:0]   ae;
    logic [2:0]           neg;
  } p1_side_t;

  // carried beside the second kmax divide
  typedef struct packed {
    logic                 pinned;
    logic [UW-1:0]        m;
    logic [UW-1:0]        lim;
    logic [UW-1:0]        k1;
    logic [2:0][DW-1:0]   ae;
    logic [2:0]           neg;
  } p2_side_t;

  // carried beside the norm square root
  typedef struct packed {
    logic                 pinned;
    logic [UW-1:0]        lim;
    logic [2:0][UW-1:0]   mag;
    logic [2:0]           neg;
  } sq_side_t;

  // one force lane through the clamp divide
  typedef struct packed {
    logic [UW-1:0] mag;
    logic          neg;
  } lane_t;

  // lane x also carries the per-word flags
  typedef struct packed {
    logic          pinned;
    logic          big;
    logic [UW-1:0] damp;
    logic [UW-1:0] mag;
    logic          neg;
  } lane0_t;

endpackage

>>> design/pbsf_div.sv
module pbsf_div import pbsf_pkg::*; #(
  parameter int unsigned N_W    = 48,
  parameter int unsigned D_W    = 33,
  parameter int unsigned Q_W    = 31,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [N_W-1:0]    dividend_i,
  input  logic [D_W-1:0]    divisor_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quot_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned R0_W = N_W - Q_W;
  localparam int unsigned C_W  = R0_W + D_W;

  logic [Q_W:0]                 v_q;
  logic [Q_W:0][D_W-1:0]        rem_q;
  logic [Q_W:0][D_W-1:0]        dv_q;
  logic [Q_W:0][Q_W-1:0]        low_q;
  logic [Q_W:0][Q_W-1:0]        quo_q;
  logic [Q_W:0]                 ovf_q;
  logic [Q_W:0][SIDE_W-1:0]     side_q;

  logic [Q_W-1:0][D_W:0]        trial;
  logic [Q_W-1:0][D_W:0]        diff;
  logic [Q_W-1:0]               ge;
  logic [Q_W-1:0][D_W-1:0]      rem_d;

  // one quotient bit per stage
  always_comb begin
    for (int i = 0; i < Q_W; i++) begin
      trial[i] = {rem_q[i], low_q[i][Q_W-1]};
      ge[i]    = trial[i] >= {1'b0, dv_q[i]};
      diff[i]  = trial[i] - {1'b0, dv_q[i]};
      rem_d[i] = ge[i] ? diff[i][D_W-1:0] : trial[i][D_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Q_W-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= D_W'(dividend_i[N_W-1:Q_W]);
      low_q[0]  <= dividend_i[Q_W-1:0];
      quo_q[0]  <= '0;
      dv_q[0]   <= divisor_i;
      // quotient beyond Q_W bits (zero divisor too) saturates
      ovf_q[0]  <= C_W'(dividend_i[N_W-1:Q_W]) >= C_W'(divisor_i);
      side_q[0] <= side_i;
      for (int i = 0; i < Q_W; i++) begin
        rem_q[i+1]  <= rem_d[i];
        low_q[i+1]  <= low_q[i] << 1;
        quo_q[i+1]  <= {quo_q[i][Q_W-2:0], ge[i]};
        dv_q[i+1]   <= dv_q[i];
        ovf_q[i+1]  <= ovf_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign valid_o = v_q[Q_W];
  assign quot_o  = ovf_q[Q_W] ? {Q_W{1'b1}} : quo_q[Q_W];
  assign side_o  = side_q[Q_W];

endmodule

>>> design/pbsf_sqrt.sv
module pbsf_sqrt import pbsf_pkg::*; #(
  parameter int unsigned IN_W   = 64,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [IN_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [IN_W/2-1:0] root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned R_W = IN_W / 2;

  logic [R_W:0]                v_q;
  logic [R_W:0][R_W:0]         rem_q;
  logic [R_W:0][R_W-1:0]       root_q;
  logic [R_W:0][IN_W-1:0]      x_q;
  logic [R_W:0][SIDE_W-1:0]    side_q;

  logic [R_W-1:0][R_W+2:0]     rem_n;
  logic [R_W-1:0][R_W+2:0]     trial;
  logic [R_W-1:0][R_W+2:0]     diff;
  logic [R_W-1:0]              ge;

  // one root bit per stage, two radicand bits in
  always_comb begin
    for (int i = 0; i < R_W; i++) begin
      rem_n[i] = {rem_q[i], x_q[i][IN_W-1 -: 2]};
      trial[i] = {1'b0, root_q[i], 2'b01};
      ge[i]    = rem_n[i] >= trial[i];
      diff[i]  = rem_n[i] - trial[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[R_W-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      x_q[0]    <= rad_i;
      side_q[0] <= side_i;
      for (int i = 0; i < R_W; i++) begin
        rem_q[i+1]  <= ge[i] ? diff[i][R_W:0] : rem_n[i][R_W:0];
        root_q[i+1] <= {root_q[i][R_W-2:0], ge[i]};
        x_q[i+1]    <= x_q[i] << 2;
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign valid_o = v_q[R_W];
  assign root_o  = root_q[R_W];
  assign side_o  = side_q[R_W];

endmodule

>>> design/pinned_bubble_spring_force_unit.sv
// throughput: one word per cycle unless the output stalls; every stage is a
//   register, the dividers and square roots are unrolled one bit per stage,
//   so nothing is shared
// a stall on the output freezes the whole pipeline, no word is lost or repeated
// reset: step_time returns to 1.0, all valid bits clear, the pipeline is empty
module pinned_bubble_spring_force_unit import pbsf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // input words
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 pinned_i,
  input  logic [UW-1:0]        surface_tension_i,
  input  logic [UW-1:0]        diameter_i,
  input  logic [UW-1:0]        bubble_mass_i,
  input  logic signed [31:0]   offset_x_i,
  input  logic signed [31:0]   offset_y_i,
  input  logic signed [31:0]   offset_z_i,
  input  logic signed [17:0]   normal_x_i,
  input  logic signed [17:0]   normal_y_i,
  input  logic signed [17:0]   normal_z_i,
  // result words
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [31:0]   force_x_o,
  output logic signed [31:0]   force_y_o,
  output logic signed [31:0]   force_z_o,
  output logic [UW-1:0]        damping_coeff_o
);

  // ---------------------------------------------------------------- config
  logic [UW-1:0] dt_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= STEP_TIME_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_STEP_TIME)) begin
      dt_q <= pwdata[UW-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_STEP_TIME) ? {1'b0, dt_q} : '0;

  // ------------------------------------------------------- pipeline control
  // the whole pipe moves together; a bubble in the output register lets it run
  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // ---------------------------------------------------- stage a: input regs
  logic                 va_q;
  logic                 a_pinned_q;
  logic [UW-1:0]        a_sig_q, a_d_q, a_m_q;
  logic [2:0][31:0]     a_off_q;
  logic [2:0][17:0]     a_n_q;

  // ----------------------------------------- stage b: sigma*d and |n|*d/2
  logic                 vb_q;
  logic                 b_pinned_q;
  logic [UW-1:0]        b_d_q, b_m_q;
  logic [61:0]          b_sd_q;
  logic [2:0][31:0]     b_off_q;
  logic [2:0][UW-1:0]   b_half_q;
  logic [2:0]           b_nneg_q;
  logic [2:0][17:0]     n_abs;
  logic [2:0][48:0]     half_p;

  // ------------------------------------------- stage c: offset sum, clamp
  logic                 vc_q;
  logic                 c_pinned_q;
  logic [UW-1:0]        c_d_q, c_m_q, c_s1_q;
  logic [2:0][31:0]     c_ae_q;
  logic [2:0]           c_neg_q;
  logic [2:0][33:0]     e_w;

  // ---------------------------------------------- stage d: limit product
  logic                 vd_q;
  logic                 d_pinned_q;
  logic [UW-1:0]        d_d_q, d_m_q;
  logic [62:0]          d_lp_q;
  logic [2:0][31:0]     d_ae_q;
  logic [2:0]           d_neg_q;
  logic [UW-1:0]        lim_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_abs[i]  = a_n_q[i][17] ? 18'(-a_n_q[i]) : a_n_q[i];
      half_p[i] = n_abs[i] * a_d_q;
      e_w[i]    = b_nneg_q[i] ? ({{2{b_off_q[i][31]}}, b_off_q[i]} - {3'b000, b_half_q[i]})
                              : ({{2{b_off_q[i][31]}}, b_off_q[i]} + {3'b000, b_half_q[i]});
    end
  end

  assign lim_d = d_lp_q[62:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_pinned_q <= pinned_i;
      a_sig_q    <= surface_tension_i;
      a_d_q      <= diameter_i;
      a_m_q      <= bubble_mass_i;
      a_off_q    <= {offset_z_i, offset_y_i, offset_x_i};
      a_n_q      <= {normal_z_i, normal_y_i, normal_x_i};

      b_pinned_q <= a_pinned_q;
      b_d_q      <= a_d_q;
      b_m_q      <= a_m_q;
      b_sd_q     <= a_sig_q * a_d_q;
      b_off_q    <= a_off_q;
      for (int i = 0; i < 3; i++) begin
        b_half_q[i] <= half_p[i][47:17];
        b_nneg_q[i] <= a_n_q[i][17];
      end

      c_pinned_q <= b_pinned_q;
      c_d_q      <= b_d_q;
      c_m_q      <= b_m_q;
      c_s1_q     <= (|b_sd_q[61:47]) ? SMAX : b_sd_q[46:16];
      for (int i = 0; i < 3; i++) begin
        c_neg_q[i] <= e_w[i][33];
        c_ae_q[i]  <= e_w[i][33] ? 32'(-e_w[i]) : e_w[i][31:0];
      end

      d_pinned_q <= c_pinned_q;
      d_d_q      <= c_d_q;
      d_m_q      <= c_m_q;
      d_lp_q     <= c_s1_q * LIMIT_COEF_Q32;
      d_ae_q     <= c_ae_q;
      d_neg_q    <= c_neg_q;
    end
  end

  // ------------------------- divide pair: k1 = L<<17 / 3d, q = m<<16 / dt
  p1_side_t      p1_in, p1_out;
  logic [UW-1:0] k1_lim_out;
  logic [UW-1:0] q_quot, k1_quot;
  logic          vq, vk1;

  assign p1_in = '{pinned: d_pinned_q, m: d_m_q, ae: d_ae_q, neg: d_neg_q};

  pbsf_div #(.N_W(48), .D_W(33), .Q_W(UW), .SIDE_W($bits(p1_side_t))) u_div_q (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vd_q),
    .dividend_i({1'b0, d_m_q, 16'h0000}),
    .divisor_i({2'b00, dt_q}),
    .side_i(p1_in),
    .valid_o(vq), .quot_o(q_quot), .side_o(p1_out)
  );

  pbsf_div #(.N_W(48), .D_W(33), .Q_W(UW), .SIDE_W(UW)) u_div_k1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vd_q),
    .dividend_i({lim_d, 17'h00000}),
    .divisor_i({2'b00, d_d_q} + {1'b0, d_d_q, 1'b0}),
    .side_i(lim_d),
    .valid_o(vk1), .quot_o(k1_quot), .side_o(k1_lim_out)
  );

  // -------------------------------------------- kmax = (q<<16) / dt
  p2_side_t      p2_in, p2_out;
  logic [UW-1:0] kmax_quot;
  logic          vkm;

  assign p2_in = '{pinned: p1_out.pinned, m: p1_out.m, lim: k1_lim_out, k1: k1_quot,
                   ae: p1_out.ae, neg: p1_out.neg};

  pbsf_div #(.N_W(48), .D_W(33), .Q_W(UW), .SIDE_W($bits(p2_side_t))) u_div_kmax (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vq),
    .dividend_i({1'b0, q_quot, 16'h0000}),
    .divisor_i({2'b00, dt_q}),
    .side_i(p2_in),
    .valid_o(vkm), .quot_o(kmax_quot), .side_o(p2_out)
  );

  // ---------------------------------- stage f: spring constant k = min
  logic                 vf_q, f_pinned_q;
  logic [UW-1:0]        f_k_q, f_m_q, f_lim_q;
  logic [2:0][31:0]     f_ae_q;
  logic [2:0]           f_neg_q;

  // ---------------------------------- stage g: k*|e|, m*k
  logic                 vg_q, g_pinned_q;
  logic [UW-1:0]        g_lim_q;
  logic [2:0][62:0]     g_pf_q;
  logic [61:0]          g_pmk_q;
  logic [2:0]           g_neg_q;

  // ---------------------------------- stage h: force magnitudes, 4*m*k
  logic                 vh_q, h_pinned_q;
  logic [UW-1:0]        h_lim_q;
  logic [2:0][UW-1:0]   h_mag_q;
  logic [63:0]          h_mk4_q;
  logic [2:0]           h_neg_q;

  // ---------------------------------- stage i: squares and L^2
  logic                 vi_q, i_pinned_q;
  logic [UW-1:0]        i_lim_q;
  logic [2:0][UW-1:0]   i_mag_q;
  logic [2:0][61:0]     i_sq_q;
  logic [61:0]          i_ll_q;
  logic [63:0]          i_mk4_q;
  logic [2:0]           i_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
      vg_q <= 1'b0;
      vh_q <= 1'b0;
      vi_q <= 1'b0;
    end else if (en) begin
      vf_q <= vkm;
      vg_q <= vf_q;
      vh_q <= vg_q;
      vi_q <= vh_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_pinned_q <= p2_out.pinned;
      f_k_q      <= (p2_out.k1 < kmax_quot) ? p2_out.k1 : kmax_quot;
      f_m_q      <= p2_out.m;
      f_lim_q    <= p2_out.lim;
      f_ae_q     <= p2_out.ae;
      f_neg_q    <= p2_out.neg;

      g_pinned_q <= f_pinned_q;
      g_lim_q    <= f_lim_q;
      for (int i = 0; i < 3; i++) g_pf_q[i] <= f_k_q * f_ae_q[i];
      g_pmk_q    <= f_m_q * f_k_q;
      g_neg_q    <= f_neg_q;

      h_pinned_q <= g_pinned_q;
      h_lim_q    <= g_lim_q;
      for (int i = 0; i < 3; i++) begin
        h_mag_q[i] <= (|g_pf_q[i][62:47]) ? SMAX : g_pf_q[i][46:16];
      end
      h_mk4_q    <= {g_pmk_q, 2'b00};
      h_neg_q    <= g_neg_q;

      i_pinned_q <= h_pinned_q;
      i_lim_q    <= h_lim_q;
      i_mag_q    <= h_mag_q;
      for (int i = 0; i < 3; i++) i_sq_q[i] <= h_mag_q[i] * h_mag_q[i];
      i_ll_q     <= h_lim_q * h_lim_q;
      i_mk4_q    <= h_mk4_q;
      i_neg_q    <= h_neg_q;
    end
  end

  // --------------------- square roots: |f| for the clamp, damping sqrt(4mk)
  logic [63:0]  sumsq;
  logic         big_w;
  sq_side_t     sq_in, sq_out;
  logic [31:0]  r_root, c_root;
  logic         vr, vcr, big_out;

  assign sumsq = 64'(i_sq_q[0]) + 64'(i_sq_q[1]) + 64'(i_sq_q[2]);
  assign big_w = sumsq > 64'(i_ll_q);
  assign sq_in = '{pinned: i_pinned_q, lim: i_lim_q, mag: i_mag_q, neg: i_neg_q};

  pbsf_sqrt #(.IN_W(64), .SIDE_W($bits(sq_side_t))) u_sqrt_norm (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vi_q),
    .rad_i(sumsq), .side_i(sq_in),
    .valid_o(vr), .root_o(r_root), .side_o(sq_out)
  );

  pbsf_sqrt #(.IN_W(64), .SIDE_W(1)) u_sqrt_damp (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vi_q),
    .rad_i(i_mk4_q), .side_i(big_w),
    .valid_o(vcr), .root_o(c_root), .side_o(big_out)
  );

  // ---------------------------------- stage k: |f_i|*L, damping clamp
  logic                 vk_q, k_pinned_q, k_big_q;
  logic [UW-1:0]        k_damp_q;
  logic [31:0]          k_r_q;
  logic [2:0][61:0]     k_num_q;
  logic [2:0][UW-1:0]   k_mag_q;
  logic [2:0]           k_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vk_q <= 1'b0;
    end else if (en) begin
      vk_q <= vr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      k_pinned_q <= sq_out.pinned;
      k_big_q    <= big_out;
      k_damp_q   <= c_root[31] ? SMAX : c_root[30:0];
      k_r_q      <= r_root;
      for (int i = 0; i < 3; i++) k_num_q[i] <= sq_out.mag[i] * sq_out.lim;
      k_mag_q    <= sq_out.mag;
      k_neg_q    <= sq_out.neg;
    end
  end

  // ------------------------- clamp divides: f_i*L / |f|, never beyond L
  lane0_t        l0_in, l0_out;
  lane_t         l1_in, l1_out, l2_in, l2_out;
  logic [UW-1:0] cq0, cq1, cq2;
  logic          vcl0, vcl1, vcl2;

  assign l0_in = '{pinned: k_pinned_q, big: k_big_q, damp: k_damp_q,
                   mag: k_mag_q[0], neg: k_neg_q[0]};
  assign l1_in = '{mag: k_mag_q[1], neg: k_neg_q[1]};
  assign l2_in = '{mag: k_mag_q[2], neg: k_neg_q[2]};

  pbsf_div #(.N_W(62), .D_W(32), .Q_W(UW), .SIDE_W($bits(lane0_t))) u_div_cx (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vk_q),
    .dividend_i(k_num_q[0]), .divisor_i(k_r_q), .side_i(l0_in),
    .valid_o(vcl0), .quot_o(cq0), .side_o(l0_out)
  );

  pbsf_div #(.N_W(62), .D_W(32), .Q_W(UW), .SIDE_W($bits(lane_t))) u_div_cy (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vk_q),
    .dividend_i(k_num_q[1]), .divisor_i(k_r_q), .side_i(l1_in),
    .valid_o(vcl1), .quot_o(cq1), .side_o(l1_out)
  );

  pbsf_div #(.N_W(62), .D_W(32), .Q_W(UW), .SIDE_W($bits(lane_t))) u_div_cz (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vk_q),
    .dividend_i(k_num_q[2]), .divisor_i(k_r_q), .side_i(l2_in),
    .valid_o(vcl2), .quot_o(cq2), .side_o(l2_out)
  );

  // ------------------------------------- output register: sign, pinned gate
  logic [2:0][UW-1:0] fm;
  logic [2:0]         fneg;
  logic [2:0][31:0]   fout;
  logic [2:0][31:0]   force_q;
  logic [UW-1:0]      damp_q;

  always_comb begin
    fm[0]   = l0_out.big ? cq0 : l0_out.mag;
    fm[1]   = l0_out.big ? cq1 : l1_out.mag;
    fm[2]   = l0_out.big ? cq2 : l2_out.mag;
    fneg    = {l2_out.neg, l1_out.neg, l0_out.neg};
    for (int i = 0; i < 3; i++) begin
      fout[i] = fneg[i] ? 32'(-{1'b0, fm[i]}) : {1'b0, fm[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vcl0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      force_q <= l0_out.pinned ? fout : '0;
      damp_q  <= l0_out.pinned ? l0_out.damp : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign force_x_o       = force_q[0];
  assign force_y_o       = force_q[1];
  assign force_z_o       = force_q[2];
  assign damping_coeff_o = damp_q;

  // ------------------------------------------------------------ assertions
  // parallel units must stay in step
  a_div_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vq == vk1) else $error("k1 and q divides out of step");

  a_sqrt_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vr == vcr) else $error("square roots out of step");

  a_lane_trio : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vcl0 == vcl1) && (vcl0 == vcl2)) else $error("clamp lanes out of step");

  // force clamp is symmetric, the most negative code never appears
  a_no_min : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (force_x_o != 32'sh8000_0000) && (force_y_o != 32'sh8000_0000)
                    && (force_z_o != 32'sh8000_0000))
    else $error("force component at most negative code");

endmodule
